### design/rilbp_pkg.sv
package rilbp_pkg;

  // Configuration register indexes
  localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

  // Field widths fixed by the interface
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned WIDTH_BITS  = 11;
  localparam int unsigned HEIGHT_BITS = 16;
  localparam int unsigned IN_PIX_W    = 8;
  localparam int unsigned CODE_W      = 8;
  localparam int unsigned MIN_DIM     = 3;

  typedef logic [CODE_W-1:0] code_t;

  // Control that travels with a pixel from the accept stage to the pattern stage
  typedef struct packed {
    logic has_result;
    logic row_end;
    logic frame_end;
  } item_ctrl_t;

  // Smallest of the eight circular rotations of a code byte
  function automatic code_t min_rotation(code_t code);
    code_t best;
    code_t x;
    best = code;
    x    = code;
    for (int k = 0; k < CODE_W - 1; k++) begin
      x = {x[CODE_W-2:0], x[CODE_W-1]};
      if (x < best) begin
        best = x;
      end
    end
    return best;
  endfunction

endpackage

### design/rotation_invariant_lbp_core.sv
// A pixel accepted on the input is held in the window stage register, and its
// result then in the output register. Throughput: one pixel per cycle while the
// output is not stalled; the line store is read when the pixel is accepted and
// written back when the window stage retires it. Reset clears the counters, the
// window, the stage valids and the output slot, and sets width and height to 3.
// The line store is not cleared; rows are written before they are read.
module rotation_invariant_lbp_core
  import rilbp_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // pixel input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [IN_PIX_W-1:0]   pixel_i,
  // pattern output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CODE_W-1:0]     pattern_code_o,
  output logic                  row_end_o,
  output logic                  frame_end_o
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned PIX_W = PIXEL_BITS;
  localparam logic [COL_W-1:0] MAX_COL = COL_W'(MAX_WIDTH - 1);
  localparam logic [COL_W-1:0] MIN_COL = COL_W'(MIN_DIM - 1);
  localparam logic [HEIGHT_BITS-1:0] MIN_ROW = HEIGHT_BITS'(MIN_DIM - 1);

  typedef logic [PIX_W-1:0] pix_t;

  // ---------------- configuration ----------------
  logic [COL_W-1:0]       last_col_q, last_col_d;
  logic [HEIGHT_BITS-1:0] last_row_q, last_row_d;
  logic [WIDTH_BITS-1:0]  cfg_w;
  logic [HEIGHT_BITS-1:0] cfg_h;
  logic                   cfg_restart;

  assign cfg_w = cfg_data_i[WIDTH_BITS-1:0];
  assign cfg_h = cfg_data_i[HEIGHT_BITS-1:0];

  // Clamp to the supported range and keep the last column/row index
  always_comb begin
    last_col_d  = last_col_q;
    last_row_d  = last_row_q;
    cfg_restart = 1'b0;
    if (cfg_we_i) begin
      cfg_restart = 1'b1;
      unique case (cfg_index_i)
        REG_IMAGE_WIDTH: begin
          if (32'(cfg_w) < 32'(MIN_DIM)) begin
            last_col_d = MIN_COL;
          end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
            last_col_d = MAX_COL;
          end else begin
            last_col_d = COL_W'(cfg_w - WIDTH_BITS'(1));
          end
        end
        REG_IMAGE_HEIGHT: begin
          if (32'(cfg_h) < 32'(MIN_DIM)) begin
            last_row_d = MIN_ROW;
          end else begin
            last_row_d = cfg_h - HEIGHT_BITS'(1);
          end
        end
        default: begin
          cfg_restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= MIN_COL;
      last_row_q <= MIN_ROW;
    end else begin
      last_col_q <= last_col_d;
      last_row_q <= last_row_d;
    end
  end

  // ---------------- handshake ----------------
  logic       s1_valid_q, s1_valid_d;
  item_ctrl_t s1_ctrl_q;
  pix_t       s1_pix_q;
  logic [COL_W-1:0] s1_col_q;
  logic       out_valid_q, out_valid_d;
  logic       in_xfer;
  logic       s1_adv;

  // The window stage only waits when it has a result and the output slot is held
  assign in_stall_o = s1_valid_q && s1_ctrl_q.has_result && out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign s1_adv     = s1_valid_q && !in_stall_o;

  // ---------------- raster counters ----------------
  logic [COL_W-1:0]       col_q, col_d;
  logic [HEIGHT_BITS-1:0] row_q, row_d;
  logic                   at_row_end, at_frame_end;

  assign at_row_end   = (col_q == last_col_q);
  assign at_frame_end = at_row_end && (row_q == last_row_q);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_restart) begin
      col_d = '0;
      row_d = '0;
    end else if (in_xfer) begin
      if (at_row_end) begin
        col_d = '0;
        row_d = at_frame_end ? '0 : row_q + HEIGHT_BITS'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------- accept stage -> window stage ----------------
  assign s1_valid_d = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_ctrl_q  <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (in_xfer) begin
        s1_ctrl_q.has_result <= (row_q >= HEIGHT_BITS'(2)) && (col_q >= COL_W'(2));
        s1_ctrl_q.row_end    <= at_row_end;
        s1_ctrl_q.frame_end  <= at_frame_end;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_pix_q <= PIX_W'(pixel_i);
      s1_col_q <= col_q;
    end
  end

  // ---------------- line store ----------------
  // Read on accept, write back on retire. A column comes back only after at
  // least three transfers, so a read never meets a pending write of its entry.
  logic [2*PIX_W-1:0] ls_rd_data;
  pix_t               top, mid;

  rilbp_line_buf #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (2 * PIX_W)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (in_xfer),
    .rd_addr_i (col_q),
    .rd_data_o (ls_rd_data),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_col_q),
    .wr_data_i ({mid, s1_pix_q})
  );

  assign top = ls_rd_data[2*PIX_W-1:PIX_W];
  assign mid = ls_rd_data[PIX_W-1:0];

  // ---------------- window ----------------
  // left column l0..l2 and centre column m0..m2, top to bottom
  pix_t l0_q, l1_q, l2_q, m0_q, m1_q, m2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l0_q <= '0;
      l1_q <= '0;
      l2_q <= '0;
      m0_q <= '0;
      m1_q <= '0;
      m2_q <= '0;
    end else if (s1_adv) begin
      l0_q <= m0_q;
      l1_q <= m1_q;
      l2_q <= m2_q;
      m0_q <= top;
      m1_q <= mid;
      m2_q <= s1_pix_q;
    end
  end

  // ---------------- pattern ----------------
  logic [CODE_W-1:0][PIX_W-1:0] nb;
  code_t                        code;

  assign nb = {l0_q, m0_q, top, mid, s1_pix_q, m2_q, l2_q, l1_q};

  rilbp_pattern #(
    .PIXEL_BITS (PIX_W)
  ) u_pattern (
    .nb_i     (nb),
    .centre_i (m1_q),
    .code_o   (code)
  );

  // ---------------- output register ----------------
  code_t code_q;
  logic  row_end_q, frame_end_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && s1_ctrl_q.has_result) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_ctrl_q.has_result) begin
      code_q      <= code;
      row_end_q   <= s1_ctrl_q.row_end;
      frame_end_q <= s1_ctrl_q.frame_end;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pattern_code_o = code_q;
  assign row_end_o      = row_end_q;
  assign frame_end_o    = frame_end_q;

endmodule

### design/rilbp_line_buf.sv
module rilbp_line_buf #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned DATA_W = 16
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]        rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DATA_W-1:0]        wr_data_i
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  // One write port, one registered read port; read data holds between reads
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### design/rilbp_pattern.sv
module rilbp_pattern
  import rilbp_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = 8
) (
  // neighbours, MSB first: top-left, top, top-right, right,
  // bottom-right, bottom, bottom-left, left
  input  logic [CODE_W-1:0][PIXEL_BITS-1:0] nb_i,
  input  logic [PIXEL_BITS-1:0]             centre_i,
  output code_t                             code_o
);

  code_t raw;

  // One compare per neighbour
  always_comb begin
    for (int i = 0; i < CODE_W; i++) begin
      raw[i] = (nb_i[i] >= centre_i);
    end
  end

  assign code_o = min_rotation(raw);

endmodule

### design/rilbp_checker.sv
module rilbp_checker
  import rilbp_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [CODE_W-1:0] pattern_code_o,
  input logic              row_end_o,
  input logic              frame_end_o
);

  // A held result stays put until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pattern_code_o)
      && $stable(row_end_o) && $stable(frame_end_o))
    else $error("output changed while stalled");

  // The last result of a frame is also the last of its row
  a_frame_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> row_end_o)
    else $error("frame_end without row_end");

  // Input backpressure only comes from a held output
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with output free");

  // A fresh result comes from a pixel taken in an earlier input transfer
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without matching input transfer");

endmodule

bind rotation_invariant_lbp_core rilbp_checker u_rilbp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .pattern_code_o (pattern_code_o),
  .row_end_o      (row_end_o),
  .frame_end_o    (frame_end_o)
);
